// ===== hw/rtl/bucketed_hash_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// bucketed hash table core assertion macros
// short forms for the clocked implication checks used at the top level
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_CORE_ASSERT_SVH
`define BUCKETED_HASH_TABLE_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define BHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bht implication check failed");

// next-cycle implication, masked during reset
`define BHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bht next-cycle check failed");

`endif

// ===== hw/rtl/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// shared types and constants for the bucketed hash table core
// ----------------------------------------------------------------------------
package bht_pkg;

    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 32;
    localparam int DEF_N_BUCKETS  = 8;
    localparam int DEF_SLOTS      = 4;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } bht_op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_MISSING  = 3'd4
    } bht_status_t;

    typedef struct packed {
        bht_op_t             cmd;
        logic [KEY_W-1:0]    key;
        logic [VALUE_W-1:0]  value;
    } bht_req_t;

    typedef struct packed {
        bht_status_t         status;
        logic [VALUE_W-1:0]  read_value;
    } bht_rsp_t;

    typedef enum logic [1:0] {
        FSM_CLEAR = 2'd0,
        FSM_IDLE  = 2'd1,
        FSM_HASH  = 2'd2,
        FSM_EVAL  = 2'd3
    } bht_fsm_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic read;
        logic eval;
    } bht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic clear_last;
    } bht_stat_t;

endpackage

// ===== hw/rtl/bht_mod.sv =====
// ----------------------------------------------------------------------------
// bht_mod
// key modulo bucket count: a mask for powers of two, else reciprocal multiply
// ----------------------------------------------------------------------------
module bht_mod
    import bht_pkg::*;
#(
    parameter int N_BUCKETS = DEF_N_BUCKETS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_W-1:0]     key,
    output logic [((N_BUCKETS > 1) ? $clog2(N_BUCKETS) : 1)-1:0] bucket,
    output logic                 done
);

    localparam int  BUCKET_W = (N_BUCKETS > 1) ? $clog2(N_BUCKETS) : 1;
    localparam bit  IS_POW2  = ((N_BUCKETS & (N_BUCKETS - 1)) == 0);

    logic [BUCKET_W-1:0] rem_reg;

    assign bucket = rem_reg;

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    if (N_BUCKETS == 1)
                        rem_reg <= '0;
                    else
                        rem_reg <= key[BUCKET_W-1:0];
                end
            end
            assign done = 1'b1;
        end else begin : g_recip
            // quotient is (key * RECIP) >> SHIFT, exact for every key value
            localparam int SHIFT   = KEY_W + BUCKET_W;
            localparam int RECIP_W = KEY_W + 1;
            localparam int PROD_W  = KEY_W + RECIP_W;
            localparam logic [RECIP_W-1:0] RECIP =
                RECIP_W'(((64'd1 << SHIFT) + 64'(N_BUCKETS) - 64'd1) / 64'(N_BUCKETS));
            localparam logic [BUCKET_W-1:0] N_LO = BUCKET_W'(N_BUCKETS);

            logic [PROD_W-1:0]   prod_reg;
            logic [BUCKET_W-1:0] key_lo_reg;
            logic                run_reg;
            logic [BUCKET_W-1:0] quot_lo;

            // the remainder is below the bucket count, so low bits suffice
            assign quot_lo = prod_reg[SHIFT +: BUCKET_W];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    run_reg <= 1'b0;
                else
                    run_reg <= start;
            end

            // multiply on the taking edge, subtract on the next one
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    prod_reg   <= PROD_W'(key) * PROD_W'(RECIP);
                    key_lo_reg <= key[BUCKET_W-1:0];
                end
                if (run_reg)
                    rem_reg <= key_lo_reg - quot_lo * N_LO;
            end

            assign done = !run_reg;
        end
    endgenerate

endmodule

// ===== hw/rtl/bht_datapath.sv =====
// ----------------------------------------------------------------------------
// bht_datapath
// bucket row stores, fill counts, slot compare and result register
// ----------------------------------------------------------------------------
module bht_datapath
    import bht_pkg::*;
#(
    parameter int N_BUCKETS        = DEF_N_BUCKETS,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  bht_req_t  req,
    input  bht_cmd_t  cmd_bus,
    output bht_stat_t stat_bus,
    output logic      done,
    output bht_rsp_t  rsp
);

    localparam int BUCKET_W = (N_BUCKETS > 1) ? $clog2(N_BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);

    // row stores: one bucket per row, all slots read together
    logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0]   key_mem   [N_BUCKETS];
    logic [SLOTS_PER_BUCKET-1:0][VALUE_W-1:0] value_mem [N_BUCKETS];
    logic [CNT_W-1:0]                         fill_mem  [N_BUCKETS];

    bht_op_t                                  op_reg;
    logic [KEY_W-1:0]                         key_reg;
    logic [VALUE_W-1:0]                       value_reg;
    logic [BUCKET_W-1:0]                      bucket_reg;
    logic [BUCKET_W-1:0]                      clr_reg;
    logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0]   krow_reg;
    logic [SLOTS_PER_BUCKET-1:0][VALUE_W-1:0] vrow_reg;
    logic [CNT_W-1:0]                         fill_reg;
    bht_rsp_t                                 rsp_reg;
    logic                                     done_reg;

    logic [BUCKET_W-1:0]                      mod_bucket;
    logic [SLOTS_PER_BUCKET-1:0]              hit_vec;
    logic                                     hit_any;
    logic [SLOT_W-1:0]                        hit_slot;
    logic                                     full;
    logic [SLOT_W-1:0]                        free_slot;
    bht_rsp_t                                 rsp_next;
    logic                                     do_update;
    logic                                     do_insert;

    bht_mod #(
        .N_BUCKETS (N_BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd_bus.capture),
        .key    (req.key),
        .bucket (mod_bucket),
        .done   (stat_bus.mod_done)
    );

    assign stat_bus.clear_last = (clr_reg == BUCKET_W'(N_BUCKETS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd_bus.capture)
        begin
            op_reg    <= req.cmd;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd_bus.clear)
            clr_reg <= clr_reg + 1'b1;
    end

    // compare across the filled slots, lowest match wins
    always_comb
    begin
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            hit_vec[s] = (CNT_W'(s) < fill_reg) && (krow_reg[s] == key_reg);
        hit_any  = |hit_vec;
        hit_slot = '0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--)
            if (hit_vec[s])
                hit_slot = SLOT_W'(s);
        full      = (fill_reg == CNT_W'(SLOTS_PER_BUCKET));
        free_slot = fill_reg[SLOT_W-1:0];
    end

    always_comb
    begin
        rsp_next.read_value = '0;
        do_update = 1'b0;
        do_insert = 1'b0;
        unique case (op_reg)
            OP_PUT:
            begin
                priority if (hit_any)
                begin
                    rsp_next.status = ST_UPDATED;
                    do_update = cmd_bus.eval;
                end else if (!full)
                begin
                    rsp_next.status = ST_INSERTED;
                    do_insert = cmd_bus.eval;
                end else
                    rsp_next.status = ST_FULL;
            end
            OP_GET:
            begin
                if (hit_any)
                begin
                    rsp_next.status     = ST_FOUND;
                    rsp_next.read_value = vrow_reg[hit_slot];
                end else
                    rsp_next.status = ST_MISSING;
            end
            default: rsp_next.status = ST_MISSING;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.read)
        begin
            bucket_reg <= mod_bucket;
            krow_reg   <= key_mem[mod_bucket];
            vrow_reg   <= value_mem[mod_bucket];
            fill_reg   <= fill_mem[mod_bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_update)
            value_mem[bucket_reg][hit_slot] <= value_reg;
        else if (do_insert)
        begin
            key_mem[bucket_reg][free_slot]   <= key_reg;
            value_mem[bucket_reg][free_slot] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.clear)
            fill_mem[clr_reg] <= '0;
        else if (do_insert)
            fill_mem[bucket_reg] <= fill_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.eval)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd_bus.eval;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== hw/rtl/bht_ctrl.sv =====
// ----------------------------------------------------------------------------
// bht_ctrl
// sequencer: clearing pass, bucket hash, row read, evaluate and write back
// ----------------------------------------------------------------------------
module bht_ctrl
    import bht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output bht_cmd_t  cmd_bus,
    input  bht_stat_t stat_bus
);

    bht_fsm_t state_reg;
    bht_fsm_t state_next;
    logic     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FSM_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        busy           = (state_reg == FSM_CLEAR) || (state_reg == FSM_HASH);
        accept         = start && !busy;
        cmd_bus.capture = accept;
        cmd_bus.clear   = 1'b0;
        cmd_bus.read    = 1'b0;
        cmd_bus.eval    = 1'b0;
        state_next     = state_reg;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                cmd_bus.clear = 1'b1;
                if (stat_bus.clear_last)
                    state_next = FSM_IDLE;
            end
            FSM_IDLE:
            begin
                if (accept)
                    state_next = FSM_HASH;
            end
            FSM_HASH:
            begin
                if (stat_bus.mod_done)
                begin
                    cmd_bus.read = 1'b1;
                    state_next   = FSM_EVAL;
                end
            end
            FSM_EVAL:
            begin
                cmd_bus.eval = 1'b1;
                state_next   = accept ? FSM_HASH : FSM_IDLE;
            end
            default: state_next = FSM_CLEAR;
        endcase
    end

endmodule

// ===== hw/rtl/bucketed_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// bucketed_hash_table_core
// key/value table of fixed-size buckets, put and get commands
// ----------------------------------------------------------------------------
// a put or get word is taken when start is high and busy is low. the key is
// its own hash and the bucket is key modulo N_BUCKETS. each bucket has
// SLOTS_PER_BUCKET slots filled from slot 0. a put updates a matching key,
// otherwise fills the next free slot, or reports bucket full. a get returns
// found with the value, or not found with zero. exactly one result word
// appears per command, on rsp with done high for a single cycle, after the
// hash, the row read and the evaluation. there is no back-pressure: the
// receiver must take the word in that cycle. a new command may be taken
// while the previous result is still being written out. the hash wait
// depends on the bucket index: with a power-of-two bucket count it is a
// mask and a command goes through row read, then compare and write back;
// otherwise the remainder comes from a reciprocal multiply and then a
// subtract before the row read. after reset the fill counts are swept to
// zero, one bucket per cycle, and busy stays high until the last bucket is
// cleared, so no command is taken before then.
// ----------------------------------------------------------------------------
`include "bucketed_hash_table_core_assert.svh"

module bucketed_hash_table_core
    import bht_pkg::*;
#(
    parameter int N_BUCKETS        = DEF_N_BUCKETS,
    parameter int SLOTS_PER_BUCKET = DEF_SLOTS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bht_req_t req,
    output logic     done,
    output bht_rsp_t rsp
);

    // command and status between sequencer and datapath
    bht_cmd_t  cmd_bus;
    bht_stat_t stat_bus;

    // sequencer: clear sweep, hash wait, read, evaluate
    bht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd_bus  (cmd_bus),
        .stat_bus (stat_bus)
    );

    // stores, slot compare and the result register
    bht_datapath #(
        .N_BUCKETS        (N_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd_bus  (cmd_bus),
        .stat_bus (stat_bus),
        .done     (done),
        .rsp      (rsp)
    );

    // a taken word always moves the sequencer into the hash wait
    `BHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // every row read is followed by its evaluation
    `BHT_ASSERT_NEXT(a_read_eval, clk, rst_n, cmd_bus.read, cmd_bus.eval)
    // a result word only ever follows an evaluation cycle
    `BHT_ASSERT_IMPL(a_done_src, clk, rst_n, done, $past(cmd_bus.eval))

endmodule
